@@ rtl/core/dcl_pkg.sv @@
// Shared types and constants for the DER certificate TBS/signature locator.
// Holds the beat structs, the parse phase enum and the DER tag codes.
// No dependencies.
package dcl_pkg;

    // Upper bound on certificate size; the configured size is clipped to it.
    localparam int MAX_CERT_BYTES = 4096;

    // Saturation limit of 13-bit offsets and lengths.
    localparam logic [12:0] LIM13 = 13'h1FFF;

    // DER codes.
    localparam logic [7:0] TAG_SEQ  = 8'h30;
    localparam logic [7:0] TAG_BITS = 8'h03;
    localparam logic [7:0] LEN_LONG = 8'h80;
    localparam logic [7:0] UNUSED_ZERO = 8'h00;

    // Input beat: one certificate byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_beat;

    // Output beat: regions found or an error.
    typedef struct packed {
        logic        status;
        logic [11:0] tbs_offset;
        logic [12:0] tbs_length;
        logic [12:0] sig_offset;
        logic [11:0] sig_length;
    } t_out_beat;

    // Parse phases: for each section a tag, a first length byte and long length bytes; then skip, unused-bits and done.
    typedef enum logic [3:0] {
        PH_OUTER_TAG  = 4'd0,
        PH_OUTER_LEN1 = 4'd1,
        PH_OUTER_LENX = 4'd2,
        PH_TBS_TAG    = 4'd3,
        PH_TBS_LEN1   = 4'd4,
        PH_TBS_LENX   = 4'd5,
        PH_ALG_TAG    = 4'd6,
        PH_ALG_LEN1   = 4'd7,
        PH_ALG_LENX   = 4'd8,
        PH_BIT_TAG    = 4'd9,
        PH_BIT_LEN1   = 4'd10,
        PH_BIT_LENX   = 4'd11,
        PH_TBS_SKIP   = 4'd12,
        PH_ALG_SKIP   = 4'd13,
        PH_UNUSED     = 4'd14,
        PH_DONE       = 4'd15
    } t_phase;

    // Section of the certificate that a header belongs to.
    typedef enum logic [1:0] {
        SEC_OUTER = 2'd0,
        SEC_TBS   = 2'd1,
        SEC_ALG   = 2'd2,
        SEC_BIT   = 2'd3
    } t_sec;

endpackage

@@ rtl/core/der_cert_tbs_sig_locator.sv @@
// Top level of the DER certificate locator: parses the byte stream and reports
// the TBS region and the signature data region, or a parse error.
// Depends on dcl_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | i_in_valid/o_in_stall | i_in_beat  (t_in_beat)
//  out     | output    | o_out_valid/i_out_stall | o_out_beat (t_out_beat)
//  cfg     | input     | i_cfg_we              | i_cfg_wdata (total size)
//
// A new byte is accepted every cycle unless a stalled result beat holds the input register.
// A result beat is computed from the byte in the input register and held in the result register.
// Synchronous active-low reset clears the parse state and the size register.
// A byte waits in the input register only while a result beat is stalled.
module der_cert_tbs_sig_locator
    import dcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_beat
);

    // Handshake and pipeline registers.
    logic        r_in_valid;
    t_in_beat    r_in;
    logic        r_out_valid;
    t_out_beat   r_out;
    logic [12:0] r_total_size;

    // Parse state.
    t_phase      r_phase,      n_phase;
    logic [12:0] r_byte_index, n_byte_index;
    logic [12:0] r_len_value,  n_len_value;
    logic        r_len_ovf,    n_len_ovf;
    logic [6:0]  r_len_left,   n_len_left;
    logic [12:0] r_skip,       n_skip;
    logic [11:0] r_tbs_off,    n_tbs_off;
    logic [12:0] r_tbs_len,    n_tbs_len;

    // Working values of the parse step.
    logic        out_free;
    logic        proc;
    logic        load;
    logic        first;
    logic [7:0]  b;
    t_phase      s_phase;
    logic [12:0] s_byte_index;
    logic [12:0] s_len_value;
    logic        s_len_ovf;
    logic [6:0]  s_len_left;
    logic [12:0] s_skip;
    logic [11:0] s_tbs_off;
    logic [12:0] s_tbs_len;
    logic [12:0] bound;
    logic [13:0] pos1;
    logic [7:0]  want;
    logic        ld_fire;
    logic [12:0] ld_len;
    logic        ld_ovf;
    logic [14:0] ld_end;
    logic [14:0] cnt_end;
    logic [6:0]  left_dec;
    logic        res_fire;
    t_out_beat   res;

    // Section of a header phase.
    function automatic t_sec sec_of(input t_phase ph);
        t_sec s;
        case (ph)
            PH_OUTER_TAG, PH_OUTER_LEN1, PH_OUTER_LENX: s = SEC_OUTER;
            PH_TBS_TAG, PH_TBS_LEN1, PH_TBS_LENX:       s = SEC_TBS;
            PH_ALG_TAG, PH_ALG_LEN1, PH_ALG_LENX:       s = SEC_ALG;
            default:                                   s = SEC_BIT;
        endcase
        return s;
    endfunction

    // The parse stage advances when the result register can take a beat.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign load       = i_in_valid && !o_in_stall;

    // Effective bound is the configured size clipped to the maximum.
    assign bound = (32'(r_total_size) < MAX_CERT_BYTES) ? r_total_size
                                                        : 13'(MAX_CERT_BYTES);

    // Next parse state for the byte in the input register.
    always_comb begin
        first = r_in.first_byte;
        b     = r_in.data_byte;

        // A first byte restarts the parse from the reset state.
        s_phase      = first ? PH_OUTER_TAG : r_phase;
        s_byte_index = first ? 13'd0 : r_byte_index;
        s_len_value  = first ? 13'd0 : r_len_value;
        s_len_ovf    = first ? 1'b0  : r_len_ovf;
        s_len_left   = first ? 7'd0  : r_len_left;
        s_skip       = first ? 13'd0 : r_skip;
        s_tbs_off    = first ? 12'd0 : r_tbs_off;
        s_tbs_len    = first ? 13'd0 : r_tbs_len;

        n_phase      = s_phase;
        n_len_value  = s_len_value;
        n_len_ovf    = s_len_ovf;
        n_len_left   = s_len_left;
        n_skip       = s_skip;
        n_tbs_off    = s_tbs_off;
        n_tbs_len    = s_tbs_len;
        n_byte_index = (s_byte_index < LIM13) ? s_byte_index + 13'd1 : LIM13;

        pos1     = {1'b0, s_byte_index} + 14'd1;
        want     = (s_phase == PH_BIT_TAG) ? TAG_BITS : TAG_SEQ;
        ld_fire  = 1'b0;
        ld_len   = 13'd0;
        ld_ovf   = 1'b0;
        left_dec = s_len_left - 7'd1;
        cnt_end  = {1'b0, pos1} + 15'({b[6:0]});

        case (s_phase)
            // Tag byte of a header.
            PH_OUTER_TAG, PH_TBS_TAG, PH_ALG_TAG, PH_BIT_TAG: begin
                if (pos1 > {1'b0, bound} || b != want) begin
                    n_phase = PH_DONE;
                end else begin
                    if (s_phase == PH_TBS_TAG) begin
                        n_tbs_off = s_byte_index[11:0];
                    end
                    n_phase = t_phase'(4'(s_phase) + 4'd1);
                end
            end
            // First length byte: short form, or the count of long-form bytes.
            PH_OUTER_LEN1, PH_TBS_LEN1, PH_ALG_LEN1, PH_BIT_LEN1: begin
                if (pos1 > {1'b0, bound} || b == LEN_LONG) begin
                    n_phase = PH_DONE;
                end else begin
                    n_len_value = 13'd0;
                    n_len_ovf   = 1'b0;
                    if (b < LEN_LONG) begin
                        ld_fire = 1'b1;
                        ld_len  = 13'(b);
                    end else begin
                        n_len_left = b[6:0];
                        if (cnt_end > 15'(bound)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = t_phase'(4'(s_phase) + 4'd1);
                        end
                    end
                end
            end
            // Long-form length bytes, big-endian, saturating.
            PH_OUTER_LENX, PH_TBS_LENX, PH_ALG_LENX, PH_BIT_LENX: begin
                if (s_len_value > (LIM13 >> 8)) begin
                    n_len_ovf   = 1'b1;
                    n_len_value = LIM13;
                end else begin
                    n_len_value = {s_len_value[4:0], b};
                end
                n_len_left = left_dec;
                if (left_dec == 7'd0) begin
                    ld_fire = 1'b1;
                    ld_len  = n_len_value;
                    ld_ovf  = n_len_ovf;
                end
            end
            // Content skipping of the TBS and algorithm sequences.
            PH_TBS_SKIP, PH_ALG_SKIP: begin
                n_skip = s_skip - 13'd1;
                if (n_skip == 13'd0) begin
                    n_phase = (s_phase == PH_TBS_SKIP) ? PH_ALG_TAG : PH_BIT_TAG;
                end
            end
            // The unused-bits byte of the signature bit string ends the parse.
            PH_UNUSED: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // Completed length: bound check and move to the next part.
        ld_end = {1'b0, pos1} + 15'(ld_len);
        if (ld_fire) begin
            n_len_value = ld_len;
            if (ld_ovf || ld_end > 15'(bound)) begin
                n_phase = PH_DONE;
            end else begin
                case (sec_of(s_phase))
                    SEC_OUTER: begin
                        n_phase = PH_TBS_TAG;
                    end
                    SEC_TBS: begin
                        n_tbs_len = 13'(ld_end - 15'(s_tbs_off));
                        n_skip    = ld_len;
                        n_phase   = (ld_len == 13'd0) ? PH_ALG_TAG : PH_TBS_SKIP;
                    end
                    SEC_ALG: begin
                        n_skip  = ld_len;
                        n_phase = (ld_len == 13'd0) ? PH_BIT_TAG : PH_ALG_SKIP;
                    end
                    default: begin
                        if (ld_len == 13'd0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_UNUSED;
                        end
                    end
                endcase
            end
        end
    end

    // Result beat: every step that ends the parse reports once. Only a zero
    // unused-bits byte reports the regions; every other ending is an error.
    always_comb begin
        res_fire = (s_phase != PH_DONE) && (n_phase == PH_DONE);
        res      = '0;
        if (s_phase == PH_UNUSED && b == UNUSED_ZERO) begin
            res.status     = 1'b0;
            res.tbs_offset = s_tbs_off;
            res.tbs_length = s_tbs_len;
            res.sig_offset = pos1[12:0];
            res.sig_length = 12'(s_len_value - 13'd1);
        end else begin
            res.status = 1'b1;
        end
    end

    // Size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_size <= 13'd0;
        end else if (i_cfg_we) begin
            r_total_size <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in <= i_in_beat;
        end
    end

    // Parse state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OUTER_TAG;
            r_byte_index <= 13'd0;
            r_len_value  <= 13'd0;
            r_len_ovf    <= 1'b0;
            r_len_left   <= 7'd0;
            r_skip       <= 13'd0;
            r_tbs_off    <= 12'd0;
            r_tbs_len    <= 13'd0;
        end else if (proc) begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_len_value  <= n_len_value;
            r_len_ovf    <= n_len_ovf;
            r_len_left   <= n_len_left;
            r_skip       <= n_skip;
            r_tbs_off    <= n_tbs_off;
            r_tbs_len    <= n_tbs_len;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && res_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
